### rtl/core/frame_size_limiter_macros.svh
// assertion helpers for the frame size limiter checker
`ifndef FRAME_SIZE_LIMITER_MACROS_SVH
`define FRAME_SIZE_LIMITER_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define FSL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fsl assertion failed");

// next-cycle implication, clocked on aclk, off during reset
`define FSL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fsl assertion failed");

`endif

### rtl/core/fsl_pkg.sv
package fsl_pkg;

    localparam int DIM_BITS         = 14;
    localparam int CFG_IDX_BITS     = 2;
    localparam int RESET_MAX_WIDTH  = 4048;
    localparam int RESET_MAX_HEIGHT = 3040;
    localparam int RESET_MAX_PIXELS = 2880 * 1800;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MAX_WIDTH  = 2'd0,
        CFG_MAX_HEIGHT = 2'd1,
        CFG_MAX_PIXELS = 2'd2
    } cfg_idx_t;

endpackage

### rtl/core/fsl_div_cell.sv
// one restoring division step per cell
module fsl_div_cell #(
    parameter int DW = 14,
    parameter int NW = 14,
    parameter int SW = 29
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          valid_in,
    input  logic [DW-1:0] rem_in,
    input  logic [NW-1:0] nq_in,
    input  logic [DW-1:0] den_in,
    input  logic [SW-1:0] side_in,
    output logic          valid_out,
    output logic [DW-1:0] rem_out,
    output logic [NW-1:0] nq_out,
    output logic [DW-1:0] den_out,
    output logic [SW-1:0] side_out
);

    logic          valid_reg;
    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] nq_reg, nq_next;
    logic [DW-1:0] den_reg;
    logic [SW-1:0] side_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    always_comb begin
        trial    = {rem_in, nq_in[NW-1]};
        diff     = trial - {1'b0, den_in};
        ge       = trial >= {1'b0, den_in};
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        nq_next  = {nq_in[NW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            nq_reg   <= nq_next;
            den_reg  <= den_in;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign nq_out    = nq_reg;
    assign den_out   = den_reg;
    assign side_out  = side_reg;

endmodule

### rtl/core/fsl_sqrt_cell.sv
// one digit-by-digit square root step per cell, two value bits in, one root bit out
module fsl_sqrt_cell #(
    parameter int RW = 14,
    parameter int SW = 29
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            valid_in,
    input  logic [RW:0]     rem_in,
    input  logic [RW-1:0]   root_in,
    input  logic [2*RW-1:0] val_in,
    input  logic [SW-1:0]   side_in,
    output logic            valid_out,
    output logic [RW:0]     rem_out,
    output logic [RW-1:0]   root_out,
    output logic [2*RW-1:0] val_out,
    output logic [SW-1:0]   side_out
);

    localparam int VW = 2 * RW;

    logic          valid_reg;
    logic [RW:0]   rem_reg, rem_next;
    logic [RW-1:0] root_reg, root_next;
    logic [VW-1:0] val_reg, val_next;
    logic [SW-1:0] side_reg;
    logic [RW+2:0] trial;
    logic [RW+2:0] test;
    logic [RW+2:0] diff;
    logic          ge;

    always_comb begin
        trial     = {rem_in, val_in[VW-1:VW-2]};
        test      = {1'b0, root_in, 2'b01};
        diff      = trial - test;
        ge        = trial >= test;
        rem_next  = ge ? diff[RW:0] : trial[RW:0];
        root_next = {root_in[RW-2:0], ge};
        val_next  = {val_in[VW-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            val_reg  <= val_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign val_out   = val_reg;
    assign side_out  = side_reg;

endmodule

### rtl/core/frame_size_limiter.sv
// frame size limiter: clamps a frame size to width, height and pixel-count limits
// while keeping the aspect ratio
// input channel s_*: one transaction carries the source width and height
// output channel m_*: one transaction per input with the limited width and height
// and size_error (set when the area step gives a zero width, both sizes then 0)
// config port: cfg_we writes cfg_data into register cfg_index at the clock edge
// (0 max_width, 1 max_height, 2 max_pixels); other indexes are ignored
// the pipeline is a chain of division and square root cells: width step, height
// step, area quotient (2*DIM_BITS cells), square root and final pixel division
// (2*DIM_BITS cells), one bit per cell, with five register stages at the start,
// between the steps and at the end
// throughput is one transaction per cycle unless stalled; every cell hands its item on
// each enabled cycle; when the receiver stalls with a result waiting, the whole
// chain freezes and s_ready drops in the same cycle; it comes back as soon as m_ready
// is seen; reset (aresetn low, synchronous) empties the chain and loads the default
// limits 4048, 3040 and 2880*1800
module frame_size_limiter #(
    parameter int DIM_BITS = fsl_pkg::DIM_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DIM_BITS-1:0]   s_src_width,
    input  logic [DIM_BITS-1:0]   s_src_height,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DIM_BITS-1:0]   m_out_width,
    output logic [DIM_BITS-1:0]   m_out_height,
    output logic                  m_size_error,
    input  logic                  cfg_we,
    input  logic [fsl_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [2*DIM_BITS-1:0] cfg_data
);

    localparam int D  = DIM_BITS;
    localparam int P  = 2 * DIM_BITS;
    localparam int T  = 3 * DIM_BITS;
    localparam int SW = P + 1;

    // limit registers
    logic [D-1:0] max_width_reg;
    logic [D-1:0] max_height_reg;
    logic [P-1:0] max_pixels_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_width_reg  <= D'(fsl_pkg::RESET_MAX_WIDTH);
            max_height_reg <= D'(fsl_pkg::RESET_MAX_HEIGHT);
            max_pixels_reg <= P'(fsl_pkg::RESET_MAX_PIXELS);
        end else if (cfg_we) begin
            unique case (fsl_pkg::cfg_idx_t'(cfg_index))
                fsl_pkg::CFG_MAX_WIDTH:  max_width_reg  <= cfg_data[D-1:0];
                fsl_pkg::CFG_MAX_HEIGHT: max_height_reg <= cfg_data[D-1:0];
                fsl_pkg::CFG_MAX_PIXELS: max_pixels_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: the chain moves unless a result sits unclaimed
    logic m_valid_reg;
    logic en;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // stage 0: width step setup, numerator height*max_width
    logic         s0_valid_reg;
    logic [D-1:0] s0_w_reg, s0_h_reg;
    logic         s0_c_reg;
    logic [P-1:0] s0_num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_w_reg   <= s_src_width;
            s0_h_reg   <= s_src_height;
            s0_c_reg   <= s_src_width > max_width_reg;
            s0_num_reg <= {{D{1'b0}}, s_src_height} * {{D{1'b0}}, max_width_reg};
        end
    end

    // width step division chain: quotient fits the dimension width
    logic          a_valid [0:D];
    logic [D-1:0]  a_rem   [0:D];
    logic [D-1:0]  a_nq    [0:D];
    logic [D-1:0]  a_den   [0:D];
    logic [SW-1:0] a_side  [0:D];

    assign a_valid[0] = s0_valid_reg;
    assign a_rem[0]   = s0_num_reg[P-1:D];
    assign a_nq[0]    = s0_num_reg[D-1:0];
    assign a_den[0]   = s0_w_reg;
    assign a_side[0]  = {s0_c_reg, s0_w_reg, s0_h_reg};

    for (genvar i = 0; i < D; i++) begin : g_a
        fsl_div_cell #(.DW(D), .NW(D), .SW(SW)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .valid_in(a_valid[i]), .rem_in(a_rem[i]), .nq_in(a_nq[i]),
            .den_in(a_den[i]), .side_in(a_side[i]),
            .valid_out(a_valid[i+1]), .rem_out(a_rem[i+1]), .nq_out(a_nq[i+1]),
            .den_out(a_den[i+1]), .side_out(a_side[i+1])
        );
    end

    // stage 1: apply width step, set up height step
    logic         a_c;
    logic [D-1:0] w1, h1;
    always_comb begin
        a_c = a_side[D][P];
        w1  = a_c ? max_width_reg : a_side[D][P-1:D];
        h1  = a_c ? {a_nq[D][D-1:1], 1'b0} : a_side[D][D-1:0];
    end

    logic         s1_valid_reg;
    logic [D-1:0] s1_w_reg, s1_h_reg;
    logic         s1_c_reg;
    logic [P-1:0] s1_num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= a_valid[D];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_w_reg   <= w1;
            s1_h_reg   <= h1;
            s1_c_reg   <= h1 > max_height_reg;
            s1_num_reg <= {{D{1'b0}}, w1} * {{D{1'b0}}, max_height_reg};
        end
    end

    // height step division chain
    logic          b_valid [0:D];
    logic [D-1:0]  b_rem   [0:D];
    logic [D-1:0]  b_nq    [0:D];
    logic [D-1:0]  b_den   [0:D];
    logic [SW-1:0] b_side  [0:D];

    assign b_valid[0] = s1_valid_reg;
    assign b_rem[0]   = s1_num_reg[P-1:D];
    assign b_nq[0]    = s1_num_reg[D-1:0];
    assign b_den[0]   = s1_h_reg;
    assign b_side[0]  = {s1_c_reg, s1_w_reg, s1_h_reg};

    for (genvar i = 0; i < D; i++) begin : g_b
        fsl_div_cell #(.DW(D), .NW(D), .SW(SW)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .valid_in(b_valid[i]), .rem_in(b_rem[i]), .nq_in(b_nq[i]),
            .den_in(b_den[i]), .side_in(b_side[i]),
            .valid_out(b_valid[i+1]), .rem_out(b_rem[i+1]), .nq_out(b_nq[i+1]),
            .den_out(b_den[i+1]), .side_out(b_side[i+1])
        );
    end

    // stage 2: apply height step, form area and max_pixels*width
    logic         b_c;
    logic [D-1:0] w2, h2;
    always_comb begin
        b_c = b_side[D][P];
        w2  = b_c ? {b_nq[D][D-1:2], 2'b00} : b_side[D][P-1:D];
        h2  = b_c ? max_height_reg : b_side[D][D-1:0];
    end

    logic         s2_valid_reg;
    logic [D-1:0] s2_w_reg, s2_h_reg;
    logic [P-1:0] s2_prod_reg;
    logic [T-1:0] s2_pnum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= b_valid[D];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_w_reg    <= w2;
            s2_h_reg    <= h2;
            s2_prod_reg <= {{D{1'b0}}, w2} * {{D{1'b0}}, h2};
            s2_pnum_reg <= {{D{1'b0}}, max_pixels_reg} * {{P{1'b0}}, w2};
        end
    end

    // area step: max_pixels*width/height, below width squared when the area is over the limit
    logic          c_valid [0:P];
    logic [D-1:0]  c_rem   [0:P];
    logic [P-1:0]  c_nq    [0:P];
    logic [D-1:0]  c_den   [0:P];
    logic [SW-1:0] c_side  [0:P];

    assign c_valid[0] = s2_valid_reg;
    assign c_rem[0]   = s2_pnum_reg[T-1:P];
    assign c_nq[0]    = s2_pnum_reg[P-1:0];
    assign c_den[0]   = s2_h_reg;
    assign c_side[0]  = {s2_prod_reg > max_pixels_reg, s2_w_reg, s2_h_reg};

    for (genvar i = 0; i < P; i++) begin : g_c
        fsl_div_cell #(.DW(D), .NW(P), .SW(SW)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .valid_in(c_valid[i]), .rem_in(c_rem[i]), .nq_in(c_nq[i]),
            .den_in(c_den[i]), .side_in(c_side[i]),
            .valid_out(c_valid[i+1]), .rem_out(c_rem[i+1]), .nq_out(c_nq[i+1]),
            .den_out(c_den[i+1]), .side_out(c_side[i+1])
        );
    end

    // integer square root chain, one root bit per cell
    logic          r_valid [0:D];
    logic [D:0]    r_rem   [0:D];
    logic [D-1:0]  r_root  [0:D];
    logic [P-1:0]  r_val   [0:D];
    logic [SW-1:0] r_side  [0:D];

    assign r_valid[0] = c_valid[P];
    assign r_rem[0]   = '0;
    assign r_root[0]  = '0;
    assign r_val[0]   = c_nq[P];
    assign r_side[0]  = c_side[P];

    for (genvar i = 0; i < D; i++) begin : g_r
        fsl_sqrt_cell #(.RW(D), .SW(SW)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .valid_in(r_valid[i]), .rem_in(r_rem[i]), .root_in(r_root[i]),
            .val_in(r_val[i]), .side_in(r_side[i]),
            .valid_out(r_valid[i+1]), .rem_out(r_rem[i+1]), .root_out(r_root[i+1]),
            .val_out(r_val[i+1]), .side_out(r_side[i+1])
        );
    end

    // stage 3: area width rounded to a multiple of 4
    logic          s3_valid_reg;
    logic [D-1:0]  s3_w_reg;
    logic [SW-1:0] s3_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s3_valid_reg <= r_valid[D];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_w_reg    <= {r_root[D][D-1:2], 2'b00};
            s3_side_reg <= r_side[D];
        end
    end

    // area height: max_pixels/width
    logic          e_valid [0:P];
    logic [D-1:0]  e_rem   [0:P];
    logic [P-1:0]  e_nq    [0:P];
    logic [D-1:0]  e_den   [0:P];
    logic [SW-1:0] e_side  [0:P];

    assign e_valid[0] = s3_valid_reg;
    assign e_rem[0]   = '0;
    assign e_nq[0]    = max_pixels_reg;
    assign e_den[0]   = s3_w_reg;
    assign e_side[0]  = s3_side_reg;

    for (genvar i = 0; i < P; i++) begin : g_e
        fsl_div_cell #(.DW(D), .NW(P), .SW(SW)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .valid_in(e_valid[i]), .rem_in(e_rem[i]), .nq_in(e_nq[i]),
            .den_in(e_den[i]), .side_in(e_side[i]),
            .valid_out(e_valid[i+1]), .rem_out(e_rem[i+1]), .nq_out(e_nq[i+1]),
            .den_out(e_den[i+1]), .side_out(e_side[i+1])
        );
    end

    // final selection: area step skipped, zero width, or saturated even height
    logic [D-1:0] w_next, h_next;
    logic         err_next;
    logic [D-1:0] e_w3;
    logic [P-1:0] e_q;

    always_comb begin
        e_w3     = e_den[P];
        e_q      = e_nq[P];
        w_next   = e_side[P][P-1:D];
        h_next   = e_side[P][D-1:0];
        err_next = 1'b0;
        if (e_side[P][P]) begin
            if (e_w3 == '0) begin
                w_next   = '0;
                h_next   = '0;
                err_next = 1'b1;
            end else begin
                w_next = e_w3;
                h_next = (|e_q[P-1:D]) ? {{(D-1){1'b1}}, 1'b0} : {e_q[D-1:1], 1'b0};
            end
        end
    end

    // output register
    logic [D-1:0] m_w_reg, m_h_reg;
    logic         m_err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= e_valid[P];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_w_reg   <= w_next;
            m_h_reg   <= h_next;
            m_err_reg <= err_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_width  = m_w_reg;
    assign m_out_height = m_h_reg;
    assign m_size_error = m_err_reg;

endmodule

### rtl/core/fsl_checker.sv
`include "frame_size_limiter_macros.svh"

module fsl_checker #(
    parameter int DIM_BITS = fsl_pkg::DIM_BITS
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [DIM_BITS-1:0] m_out_width,
    input logic [DIM_BITS-1:0] m_out_height,
    input logic                m_size_error
);

    logic [2*DIM_BITS:0] out_bus;
    assign out_bus = {m_out_width, m_out_height, m_size_error};

    // a stalled result holds
    `FSL_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(out_bus))

    // input side is free exactly when the output slot is free or drains
    `FSL_ASSERT_IMP(a_ready_flow, 1'b1, s_ready == (!m_valid || m_ready))

    // an error result carries a zero size
    `FSL_ASSERT_IMP(a_err_zero, m_valid && m_size_error, m_out_width == '0 && m_out_height == '0)

endmodule

bind frame_size_limiter fsl_checker #(.DIM_BITS(DIM_BITS)) u_fsl_checker (.*);
